[design/adjacency_matrix_dfs_defines.svh]
// Assertion macros shared by the graph traversal block.
`ifndef ADJACENCY_MATRIX_DFS_DEFINES_SVH
`define ADJACENCY_MATRIX_DFS_DEFINES_SVH

// Same-cycle implication, sampled on the block clock outside reset.
`define AMD_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on the block clock outside reset.
`define AMD_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[design/amd_pkg.sv]
// Shared types and codes for the adjacency matrix depth-first search block.
package amd_pkg;

    typedef enum logic [2:0] {
        S_IDLE,
        S_OP,
        S_TROOT,
        S_TSTEP,
        S_TFLUSH
    } t_state;

    localparam logic [2:0] OP_WRITE  = 3'd0;
    localparam logic [2:0] OP_ADD    = 3'd1;
    localparam logic [2:0] OP_REMOVE = 3'd2;
    localparam logic [2:0] OP_NEXT   = 3'd3;
    localparam logic [2:0] OP_TRAV   = 3'd4;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_NOTFOUND = 2'd1;
    localparam logic [1:0] ST_NONE     = 2'd2;

    localparam logic       CFG_VCOUNT    = 1'b0;
    localparam logic [4:0] VCOUNT_RESET  = 5'd16;
    localparam int         RESULT_CAP    = 16;
    localparam logic [4:0] CNT_LAST      = 5'(RESULT_CAP - 1);

    typedef struct packed {
        logic cap;
        logic tinit;
        logic exec;
        logic visit;
        logic from_root;
        logic pop;
        logic flush;
    } t_dp_cmd;

    typedef struct packed {
        logic in_trav;
        logic root_ok;
        logic nbr_ok;
        logic stk_empty;
        logic hold_v;
        logic out_free;
        logic cnt_cap;
    } t_dp_stat;

endpackage

[design/amd_datapath.sv]
// Datapath: label table, adjacency bits, visit marks, walk stack and result register.
module amd_datapath #(
    parameter int MAX_VERTICES = 16,
    parameter int WEIGHT_WIDTH = 16
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  amd_pkg::t_dp_cmd i_cmd,
    output amd_pkg::t_dp_stat o_stat,
    input  logic [4:0]       i_vcount,
    input  logic [71:0]      i_s_tdata,
    input  logic [2:0]       i_s_tuser,
    input  logic             i_m_tready,
    output logic             o_m_tvalid,
    output logic [23:0]      o_m_tdata,
    output logic             o_m_tlast
);
    localparam int IW   = $clog2(MAX_VERTICES);
    localparam int NW   = $clog2(MAX_VERTICES + 1);
    localparam int CMPW = (NW > 5) ? NW : 5;
    localparam logic [15:0] WMASK = (WEIGHT_WIDTH >= 16) ? 16'hFFFF :
                                    16'((32'd1 << WEIGHT_WIDTH) - 32'd1);

    logic [15:0]             r_lbl [MAX_VERTICES];
    logic [MAX_VERTICES-1:0] r_adj [MAX_VERTICES];
    logic [MAX_VERTICES-1:0] r_vis;
    logic [IW-1:0]           r_stk [MAX_VERTICES];
    logic [NW-1:0]           r_dep;
    logic [4:0]              r_cnt;
    logic [15:0]             r_hold;
    logic                    r_hold_v;
    logic                    r_out_v;
    logic [1:0]              r_out_st;
    logic [15:0]             r_out_lbl;
    logic                    r_out_last;
    logic [2:0]              r_op;
    logic [3:0]              r_slot;
    logic [15:0]             r_lblv;
    logic [15:0]             r_first;
    logic [15:0]             r_second;
    logic                    r_wnz;

    logic [NW-1:0]           n_cnt_vert;
    logic [MAX_VERTICES-1:0] inrange, match_a, match_b, gt_b;
    logic [MAX_VERTICES-1:0] root_mask, nbr_mask, next_mask;
    logic                    fa, fb, root_f, nbr_f, nx_f;
    logic [IW-1:0]           ia, ib, root_i, nbr_i, nx_i, top_v, visit_i;
    logic                    out_free, slot_ok;
    logic [1:0]              op_st;
    logic [15:0]             op_lbl;
    logic                    wr_lbl, wr_adj, adj_val;

    function automatic logic [IW:0] f_lowest(input logic [MAX_VERTICES-1:0] v);
        logic          found;
        logic [IW-1:0] idx;
        found = 1'b0;
        idx   = '0;
        for (int i = MAX_VERTICES - 1; i >= 0; i--) begin
            if (v[i]) begin
                found = 1'b1;
                idx   = IW'(i);
            end
        end
        return {found, idx};
    endfunction

    always_comb begin
        if (CMPW'(i_vcount) > CMPW'(MAX_VERTICES)) begin
            n_cnt_vert = NW'(MAX_VERTICES);
        end else begin
            n_cnt_vert = NW'(i_vcount);
        end
    end

    always_comb begin
        for (int i = 0; i < MAX_VERTICES; i++) begin
            inrange[i] = NW'(i) < n_cnt_vert;
            match_a[i] = inrange[i] && (r_lbl[i] == r_first);
            match_b[i] = inrange[i] && (r_lbl[i] == r_second);
        end
    end

    assign {fa, ia} = f_lowest(match_a);
    assign {fb, ib} = f_lowest(match_b);

    always_comb begin
        for (int j = 0; j < MAX_VERTICES; j++) begin
            gt_b[j] = IW'(j) > ib;
        end
    end

    assign top_v     = r_stk[IW'(r_dep - NW'(1))];
    assign root_mask = ~r_vis & inrange;
    assign nbr_mask  = r_adj[top_v] & ~r_vis & inrange;
    assign next_mask = r_adj[ia] & gt_b & inrange;

    assign {root_f, root_i} = f_lowest(root_mask);
    assign {nbr_f, nbr_i}   = f_lowest(nbr_mask);
    assign {nx_f, nx_i}     = f_lowest(next_mask);

    assign visit_i  = i_cmd.from_root ? root_i : nbr_i;
    assign out_free = !r_out_v || i_m_tready;
    assign slot_ok  = 32'(r_slot) < MAX_VERTICES;

    always_comb begin
        op_st   = amd_pkg::ST_NOTFOUND;
        op_lbl  = '0;
        wr_lbl  = 1'b0;
        wr_adj  = 1'b0;
        adj_val = 1'b0;
        unique case (r_op)
            amd_pkg::OP_WRITE: begin
                if (slot_ok) begin
                    wr_lbl = 1'b1;
                    op_st  = amd_pkg::ST_OK;
                end
            end
            amd_pkg::OP_ADD, amd_pkg::OP_REMOVE: begin
                if (fa && fb) begin
                    wr_adj  = 1'b1;
                    adj_val = (r_op == amd_pkg::OP_ADD) && r_wnz;
                    op_st   = amd_pkg::ST_OK;
                end
            end
            amd_pkg::OP_NEXT: begin
                if (fa && fb) begin
                    if (nx_f) begin
                        op_st  = amd_pkg::ST_OK;
                        op_lbl = r_lbl[nx_i];
                    end else begin
                        op_st = amd_pkg::ST_NONE;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < MAX_VERTICES; i++) begin
                r_lbl[i] <= '0;
                r_adj[i] <= '0;
            end
            r_vis    <= '0;
            r_dep    <= '0;
            r_cnt    <= '0;
            r_hold_v <= 1'b0;
            r_out_v  <= 1'b0;
        end else begin
            if (i_cmd.tinit) begin
                r_vis    <= '0;
                r_dep    <= '0;
                r_cnt    <= '0;
                r_hold_v <= 1'b0;
            end
            if (i_cmd.exec && wr_lbl) begin
                r_lbl[IW'(r_slot)] <= r_lblv;
            end
            if (i_cmd.exec && wr_adj) begin
                r_adj[ia][ib] <= adj_val;
                r_adj[ib][ia] <= adj_val;
            end
            if (i_cmd.visit) begin
                r_vis[visit_i] <= 1'b1;
                r_dep          <= r_dep + NW'(1);
                r_cnt          <= r_cnt + 5'd1;
                r_hold_v       <= 1'b1;
            end
            if (i_cmd.pop) begin
                r_dep <= r_dep - NW'(1);
            end
            if (i_cmd.flush) begin
                r_hold_v <= 1'b0;
            end
            if (i_cmd.exec || i_cmd.flush || (i_cmd.visit && r_hold_v)) begin
                r_out_v <= 1'b1;
            end else if (i_m_tready) begin
                r_out_v <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.cap) begin
            r_op     <= i_s_tuser;
            r_slot   <= i_s_tdata[3:0];
            r_lblv   <= i_s_tdata[19:4];
            r_first  <= i_s_tdata[35:20];
            r_second <= i_s_tdata[51:36];
            r_wnz    <= |(i_s_tdata[67:52] & WMASK);
        end
        if (i_cmd.visit) begin
            r_stk[IW'(r_dep)] <= visit_i;
            r_hold            <= r_lbl[visit_i];
        end
        if (i_cmd.exec) begin
            r_out_st   <= op_st;
            r_out_lbl  <= op_lbl;
            r_out_last <= 1'b1;
        end else if (i_cmd.flush || (i_cmd.visit && r_hold_v)) begin
            r_out_st   <= amd_pkg::ST_OK;
            r_out_lbl  <= r_hold;
            r_out_last <= i_cmd.flush;
        end
    end

    assign o_stat.in_trav   = i_s_tuser == amd_pkg::OP_TRAV;
    assign o_stat.root_ok   = root_f;
    assign o_stat.nbr_ok    = nbr_f;
    assign o_stat.stk_empty = r_dep == '0;
    assign o_stat.hold_v    = r_hold_v;
    assign o_stat.out_free  = out_free;
    assign o_stat.cnt_cap   = r_cnt == amd_pkg::CNT_LAST;

    assign o_m_tvalid = r_out_v;
    assign o_m_tdata  = {6'b0, r_out_lbl, r_out_st};
    assign o_m_tlast  = r_out_last;

endmodule

[design/amd_controller.sv]
// Controller state machine that sequences single operations and the traversal.
module amd_controller (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_s_tvalid,
    output logic              o_s_tready,
    input  amd_pkg::t_dp_stat i_stat,
    output amd_pkg::t_dp_cmd  o_cmd
);
    amd_pkg::t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= amd_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_s_tready = 1'b0;
        unique case (r_state)
            amd_pkg::S_IDLE: begin
                o_s_tready = 1'b1;
                if (i_s_tvalid) begin
                    o_cmd.cap = 1'b1;
                    if (i_stat.in_trav) begin
                        o_cmd.tinit = 1'b1;
                        n_state     = amd_pkg::S_TROOT;
                    end else begin
                        n_state = amd_pkg::S_OP;
                    end
                end
            end
            amd_pkg::S_OP: begin
                if (i_stat.out_free) begin
                    o_cmd.exec = 1'b1;
                    n_state    = amd_pkg::S_IDLE;
                end
            end
            amd_pkg::S_TROOT: begin
                if (!i_stat.root_ok) begin
                    n_state = amd_pkg::S_TFLUSH;
                end else if (!i_stat.hold_v || i_stat.out_free) begin
                    o_cmd.visit     = 1'b1;
                    o_cmd.from_root = 1'b1;
                    n_state = i_stat.cnt_cap ? amd_pkg::S_TFLUSH : amd_pkg::S_TSTEP;
                end
            end
            amd_pkg::S_TSTEP: begin
                if (i_stat.stk_empty) begin
                    n_state = amd_pkg::S_TROOT;
                end else if (!i_stat.nbr_ok) begin
                    o_cmd.pop = 1'b1;
                end else if (!i_stat.hold_v || i_stat.out_free) begin
                    o_cmd.visit = 1'b1;
                    if (i_stat.cnt_cap) begin
                        n_state = amd_pkg::S_TFLUSH;
                    end
                end
            end
            amd_pkg::S_TFLUSH: begin
                if (!i_stat.hold_v) begin
                    n_state = amd_pkg::S_IDLE;
                end else if (i_stat.out_free) begin
                    o_cmd.flush = 1'b1;
                    n_state     = amd_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = amd_pkg::S_IDLE;
            end
        endcase
    end

endmodule

[design/adjacency_matrix_dfs.sv]
// Top level of the adjacency matrix depth-first search block with its register port.
//
// Channel  Direction  Beat
// s_*      in         one operation: tuser opcode, tdata operands
// m_*      out        one result: tdata status and label, tlast on final result
// APB      in/out     vertex_count register at byte address 0
//
// A label write, edge update or neighbor query runs in two steps: capture, then execute.
// A traversal captures, then visits, pops the stack and seeks new roots step by step; it
// ends through the flush state when no root is left or after the sixteenth visit.
// The single result register stalls the walk while a finished beat is not taken.
// Reset is synchronous and clears the label table, the edges and all control state.
// A new operation is accepted only once the previous one has issued all its results.
`include "adjacency_matrix_dfs_defines.svh"

module adjacency_matrix_dfs #(
    parameter int MAX_VERTICES = 16,
    parameter int WEIGHT_WIDTH = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [71:0] s_tdata,   // slot, label_value, first_label, second_label, weight
    input  logic [2:0]  s_tuser,   // opcode
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // status, vertex_label
    output logic        m_tlast,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    logic [4:0]        r_vcount;
    amd_pkg::t_dp_cmd  w_cmd;
    amd_pkg::t_dp_stat w_stat;

    assign pready = 1'b1;
    assign prdata = {27'b0, r_vcount};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vcount <= amd_pkg::VCOUNT_RESET;
        end else if (psel && penable && pwrite && pready && (paddr[2] == amd_pkg::CFG_VCOUNT)) begin
            r_vcount <= pwdata[4:0];
        end
    end

    amd_controller u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    amd_datapath #(
        .MAX_VERTICES (MAX_VERTICES),
        .WEIGHT_WIDTH (WEIGHT_WIDTH)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (w_cmd),
        .o_stat     (w_stat),
        .i_vcount   (r_vcount),
        .i_s_tdata  (s_tdata),
        .i_s_tuser  (s_tuser),
        .i_m_tready (m_tready),
        .o_m_tvalid (m_tvalid),
        .o_m_tdata  (m_tdata),
        .o_m_tlast  (m_tlast)
    );

    `AMD_ASSERT_NOW(a_visit_no_overwrite, w_cmd.visit, w_stat.out_free || !w_stat.hold_v, "visit overwrote a pending beat")
    `AMD_ASSERT_NEXT(a_one_item, s_tvalid && s_tready, !s_tready, "second operation accepted too early")
    `AMD_ASSERT_NEXT(a_flush_last, w_cmd.flush, m_tvalid && m_tlast, "traversal end without final beat")
    `AMD_ASSERT_NEXT(a_exec_beat, w_cmd.exec, m_tvalid && m_tlast, "operation result beat missing")

endmodule

[test/amd_checker.sv]
// Checker that predicts and compares the result beats of the graph traversal block.
module amd_checker
    import amd_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [71:0] s_tdata,   // slot, label_value, first_label, second_label, weight
    input  logic [2:0]  s_tuser,   // opcode
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [23:0] m_tdata,   // status, vertex_label
    input  logic        m_tlast,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic        pready,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output int          o_fail_count,
    output int          o_pending
);

    typedef struct packed {
        logic [1:0]  status;
        logic [15:0] label;
        logic        last;
    } t_result;

    t_result     result_q[$];
    logic [15:0] label_tab[16];
    logic [15:0] weight_mat[16][16];
    logic [4:0]  vcount;
    int          fails;
    int          shown;

    assign o_fail_count = fails + result_q.size();
    assign o_pending    = result_q.size();

    function automatic int slots_in_use();
        return (vcount > 16) ? 16 : int'(vcount);
    endfunction

    function automatic int locate(logic [15:0] lbl);
        for (int i = 0; i < slots_in_use(); i++) begin
            if (label_tab[i] == lbl) return i;
        end
        return -1;
    endfunction

    task automatic note_failure(string msg);
        fails++;
        if (shown < 10) begin
            shown++;
            $display("%s", msg);
        end
    endtask

    task automatic push_result(logic [1:0] st, logic [15:0] lbl, logic lst);
        t_result r;
        r.status = st;
        r.label  = lbl;
        r.last   = lst;
        result_q.push_back(r);
    endtask

    task automatic walk_graph();
        bit visited[16];
        int stk_v[16];
        int stk_j[16];
        int depth;
        int n;
        int count;
        int top;
        int v;
        bit pushed;
        n = slots_in_use();
        count = 0;
        foreach (visited[i]) visited[i] = 0;
        for (int root = 0; root < n; root++) begin
            if (visited[root]) continue;
            visited[root] = 1;
            if (count < RESULT_CAP) begin
                push_result(ST_OK, label_tab[root], 1'b0);
                count++;
            end
            stk_v[0] = root;
            stk_j[0] = 0;
            depth = 1;
            while (depth > 0) begin
                top = depth - 1;
                v = stk_v[top];
                pushed = 0;
                for (int j = stk_j[top]; j < n; j++) begin
                    if (weight_mat[v][j] != 0 && !visited[j]) begin
                        stk_j[top] = j + 1;
                        visited[j] = 1;
                        if (count < RESULT_CAP) begin
                            push_result(ST_OK, label_tab[j], 1'b0);
                            count++;
                        end
                        if (depth < 16) begin
                            stk_v[depth] = j;
                            stk_j[depth] = 0;
                            depth++;
                        end
                        pushed = 1;
                        break;
                    end
                end
                if (!pushed) depth--;
            end
        end
        if (count > 0) result_q[result_q.size() - 1].last = 1'b1;
    endtask

    task automatic predict(logic [2:0] op, logic [71:0] d);
        logic [3:0]  slot;
        logic [15:0] lv;
        logic [15:0] fa;
        logic [15:0] sb;
        logic [15:0] w;
        int a;
        int b;
        bit found;
        slot = d[3:0];
        lv   = d[19:4];
        fa   = d[35:20];
        sb   = d[51:36];
        w    = d[67:52];
        if (op == OP_WRITE) begin
            label_tab[slot] = lv;
            push_result(ST_OK, 16'd0, 1'b1);
        end else if (op == OP_TRAV) begin
            walk_graph();
        end else if (op > OP_TRAV) begin
            push_result(ST_NOTFOUND, 16'd0, 1'b1);
        end else begin
            a = locate(fa);
            b = locate(sb);
            if (a < 0 || b < 0) begin
                push_result(ST_NOTFOUND, 16'd0, 1'b1);
            end else if (op == OP_ADD || op == OP_REMOVE) begin
                weight_mat[a][b] = (op == OP_ADD) ? w : 16'd0;
                weight_mat[b][a] = (op == OP_ADD) ? w : 16'd0;
                push_result(ST_OK, 16'd0, 1'b1);
            end else begin
                found = 0;
                for (int j = b + 1; j < slots_in_use(); j++) begin
                    if (!found && weight_mat[a][j] != 0) begin
                        push_result(ST_OK, label_tab[j], 1'b1);
                        found = 1;
                    end
                end
                if (!found) push_result(ST_NONE, 16'd0, 1'b1);
            end
        end
    endtask

    always @(posedge i_clk) begin
        t_result want;
        t_result got;
        if (!i_rst_n) begin
            result_q.delete();
            foreach (label_tab[i]) label_tab[i] = '0;
            foreach (weight_mat[i, j]) weight_mat[i][j] = '0;
            vcount = VCOUNT_RESET;
            fails = 0;
            shown = 0;
        end else begin
            if (m_tvalid && m_tready) begin
                got.status = m_tdata[1:0];
                got.label  = m_tdata[17:2];
                got.last   = m_tlast;
                if (result_q.size() == 0) begin
                    note_failure($sformatf("Unexpected result beat: status %0d label %h last %0d",
                                           got.status, got.label, got.last));
                end else begin
                    want = result_q.pop_front();
                    if (got != want || m_tdata[23:18] != '0) begin
                        note_failure($sformatf(
                            "Mismatch: expected status %0d label %h last %0d, got %0d %h %0d",
                            want.status, want.label, want.last,
                            got.status, got.label, got.last));
                    end
                end
            end
            if (s_tvalid && s_tready) predict(s_tuser, s_tdata);
            if (psel && penable && pwrite && pready && paddr == 3'({CFG_VCOUNT, 2'b00}))
                vcount = pwdata[4:0];
        end
    end

endmodule

[test/tb_adjacency_matrix_dfs.sv]
// Testbench top that drives operations and register writes into the graph traversal block.
module tb_adjacency_matrix_dfs;
    import amd_pkg::*;

    localparam logic [2:0] OP_FIRST_UNUSED = 3'd5;
    localparam logic [2:0] OP_LAST_UNUSED  = 3'd7;
    localparam int         CYCLE_LIMIT     = 1000000;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [71:0] s_tdata = '0;
    logic [2:0]  s_tuser = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;
    logic        m_tlast;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    int          fail_count;
    int          pending;
    int          send_idle_pct = 0;
    int          recv_idle_pct = 0;
    int          hold_left = 0;
    int          cycles = 0;
    logic [15:0] pool[12];

    adjacency_matrix_dfs uut (.*);

    amd_checker chk (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
        .psel(psel), .penable(penable), .pwrite(pwrite), .pready(pready),
        .paddr(paddr), .pwdata(pwdata),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    always #6 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("adjacency_matrix_dfs test failed");
            $finish;
        end
    end

    always @(negedge i_clk) begin
        if (hold_left > 0) begin
            m_tready = 1'b0;
            hold_left--;
        end else begin
            m_tready = ($urandom_range(99) >= recv_idle_pct);
        end
    end

    task automatic write_reg(logic [4:0] value);
        psel = 1'b1;
        pwrite = 1'b1;
        penable = 1'b0;
        paddr = 3'({CFG_VCOUNT, 2'b00});
        pwdata = 32'(value);
        @(negedge i_clk);
        penable = 1'b1;
        @(negedge i_clk);
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
    endtask

    task automatic send_op(logic [2:0] op, logic [3:0] slot, logic [15:0] lv,
                           logic [15:0] fa, logic [15:0] sb, logic [15:0] w);
        while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
            s_tvalid = 1'b0;
            @(negedge i_clk);
        end
        s_tuser = op;
        s_tdata = {4'b0, w, sb, fa, lv, slot};
        s_tvalid = 1'b1;
        do @(posedge i_clk); while (!s_tready);
        @(negedge i_clk);
    endtask

    function automatic logic [15:0] pick_label();
        if ($urandom_range(99) < 6) return 16'($urandom);
        return pool[$urandom_range(11)];
    endfunction

    task automatic random_op();
        int roll;
        roll = $urandom_range(99);
        if (roll < 20)
            send_op(OP_WRITE, 4'($urandom), pick_label(), 16'($urandom), 16'($urandom),
                    16'($urandom));
        else if (roll < 55)
            send_op(OP_ADD, 4'($urandom), 16'($urandom), pick_label(), pick_label(),
                    ($urandom_range(9) == 0) ? 16'd0 : 16'($urandom));
        else if (roll < 67)
            send_op(OP_REMOVE, 4'($urandom), 16'($urandom), pick_label(), pick_label(),
                    16'($urandom));
        else if (roll < 84)
            send_op(OP_NEXT, 4'($urandom), 16'($urandom), pick_label(), pick_label(),
                    16'($urandom));
        else if (roll < 96)
            send_op(OP_TRAV, 4'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                    16'($urandom));
        else
            send_op(3'($urandom_range(OP_FIRST_UNUSED, OP_LAST_UNUSED)), 4'($urandom),
                    16'($urandom), pick_label(), pick_label(), 16'($urandom));
    endtask

    task automatic drain();
        s_tvalid = 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (20) @(negedge i_clk);
    endtask

    task automatic random_run(int count, int hold_at);
        for (int k = 0; k < count; k++) begin
            if (k == hold_at) hold_left = 300;
            random_op();
        end
        drain();
    endtask

    initial begin
        pool[0] = 16'h0000;
        pool[1] = 16'hFFFF;
        for (int i = 2; i < 12; i++) pool[i] = 16'($urandom);
        repeat (5) @(negedge i_clk);
        i_rst_n = 1'b1;

        send_idle_pct = 23;
        recv_idle_pct = 77;
        write_reg(5'd16);
        send_op(OP_WRITE, 4'd0, pool[1], 16'h0, 16'h0, 16'h0);
        send_op(OP_WRITE, 4'd1, pool[2], 16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_op(OP_WRITE, 4'd2, pool[3], 16'h0, 16'h0, 16'h0);
        send_op(OP_WRITE, 4'd15, pool[4], 16'h0, 16'h0, 16'h0);
        send_op(OP_ADD, 4'd0, 16'h0, pool[1], pool[2], 16'hFFFF);
        send_op(OP_ADD, 4'd0, 16'h0, pool[2], pool[3], 16'h0001);
        send_op(OP_ADD, 4'd0, 16'h0, pool[4], pool[0], 16'h8000);
        send_op(OP_ADD, 4'd0, 16'h0, pool[3], pool[3], 16'h0000);
        send_op(OP_ADD, 4'd0, 16'h0, 16'h5A5A ^ pool[5], pool[2], 16'h0007);
        send_op(OP_NEXT, 4'd0, 16'h0, pool[2], pool[1], 16'h0);
        send_op(OP_NEXT, 4'd0, 16'h0, pool[2], pool[3], 16'h0);
        send_op(OP_NEXT, 4'd0, 16'h0, pool[3], pool[0], 16'h0);
        send_op(OP_TRAV, 4'd0, 16'h0, 16'h0, 16'h0, 16'h0);
        send_op(OP_REMOVE, 4'd0, 16'h0, pool[2], pool[3], 16'h0);
        send_op(OP_REMOVE, 4'd0, 16'h0, pool[2], 16'h1357 ^ pool[6], 16'h0);
        send_op(OP_TRAV, 4'd0, 16'h0, 16'h0, 16'h0, 16'h0);
        send_op(OP_FIRST_UNUSED, 4'd0, 16'h0, pool[1], pool[2], 16'h1);
        send_op(OP_LAST_UNUSED, 4'hF, 16'hFFFF, pool[1], pool[2], 16'hFFFF);
        random_run(80, 40);

        send_idle_pct = 77;
        recv_idle_pct = 23;
        write_reg(5'd6);
        random_run(80, 10);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_reg(5'd1);
        random_run(15, -1);
        write_reg(5'd16);
        random_run(75, 20);

        if (fail_count == 0) begin
            $display("adjacency_matrix_dfs test passed");
        end else begin
            $display("adjacency_matrix_dfs test failed");
        end
        $finish;
    end

endmodule
